[hdl/lcsr_pkg.sv]
// Shared types, constants and the micro-program of the limit-cycle switching rule.
// Holds the saturating Q24.24 helpers used by the datapath.
// No dependencies.
`timescale 1ns / 1ps

package lcsr_pkg;

  // Word format and sizes
  localparam int QW           = 48;
  localparam int NUM_SUB      = 4;
  localparam int SUB_W        = 2;
  localparam int MAX_STEPS    = 64;
  localparam int STEP_W       = 6;
  localparam int LEN_W        = 7;
  localparam int CNT_W        = 3;
  localparam int SUB_STRIDE   = 16;
  localparam int STEP_BASE    = SUB_STRIDE * NUM_SUB;
  localparam int STEP_STRIDE  = 8 + 2 * NUM_SUB;
  localparam int MEM_DEPTH    = STEP_BASE + STEP_STRIDE * MAX_STEPS;
  localparam int ADDR_W       = 11;
  localparam int TMP_DEPTH    = 32;
  localparam int TMP_W        = 5;
  localparam int PROG_LEN     = 95;
  localparam int PC_W         = 7;
  localparam int PROD_W       = 96;
  localparam int DIV_STEPS    = 96;

  localparam logic signed [QW-1:0] QMAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [QW-1:0] QMIN = 48'sh8000_0000_0000;

  // Configuration register indexes
  localparam logic [1:0] CFG_CYCLE_LENGTH    = 2'd0;
  localparam logic [1:0] CFG_SUBSYSTEM_COUNT = 2'd1;
  localparam logic [1:0] CFG_RHO             = 2'd2;

  // Micro-operations
  localparam logic [2:0] OP_MUL = 3'd0;  // res = a*b
  localparam logic [2:0] OP_MAC = 3'd1;  // res = res + a*b
  localparam logic [2:0] OP_ADD = 3'd2;  // res = a + b
  localparam logic [2:0] OP_SUB = 3'd3;  // res = a - b
  localparam logic [2:0] OP_MDV = 3'd4;  // res = a*b/den

  // Operand source kinds
  localparam logic [1:0] K_TMP = 2'd0;  // scratch word
  localparam logic [1:0] K_SUB = 2'd1;  // current subsystem block
  localparam logic [1:0] K_CUR = 2'd2;  // current step block
  localparam logic [1:0] K_NXT = 2'd3;  // next step block

  // Offsets inside a subsystem block
  localparam int C_A = 0;
  localparam int C_H = 4;
  localparam int C_E = 6;
  localparam int C_G = 10;
  localparam int C_Q = 12;
  // Offsets inside a step block (ell is shifted by two words per subsystem)
  localparam int C_P   = 0;
  localparam int C_XE  = 4;
  localparam int C_ELL = 6;

  // Scratch word map
  localparam int T_X0  = 0;
  localparam int T_X1  = 1;
  localparam int T_RHO = 2;
  localparam int T_XI0 = 3;
  localparam int T_XI1 = 4;
  localparam int T_S1  = 5;
  localparam int T_S2  = 6;
  localparam int T_AN  = 8;
  localparam int T_F   = 12;
  localparam int T_LN  = 21;
  localparam int T_V   = 23;
  localparam int T_DEN = 26;
  localparam int T_F1  = 27;
  localparam int T_F2  = 30;

  typedef struct packed {
    logic [2:0]       op;
    logic [6:0]       a;
    logic [6:0]       b;
    logic [TMP_W-1:0] dst;
  } instr_t;

  function automatic logic [6:0] st(input int n);
    return {K_TMP, TMP_W'(n)};
  endfunction

  function automatic logic [6:0] ss(input int n);
    return {K_SUB, TMP_W'(n)};
  endfunction

  function automatic logic [6:0] sc(input int n);
    return {K_CUR, TMP_W'(n)};
  endfunction

  function automatic logic [6:0] sn(input int n);
    return {K_NXT, TMP_W'(n)};
  endfunction

  function automatic instr_t mk(input logic [2:0] op, input logic [6:0] a,
                                input logic [6:0] b, input int d);
    instr_t r;
    r.op  = op;
    r.a   = a;
    r.b   = b;
    r.dst = TMP_W'(d);
    return r;
  endfunction

  // Cost of one subsystem, one word operation per entry
  function automatic instr_t lcsr_prog(input logic [PC_W-1:0] pc);
    instr_t r;
    r = mk(OP_ADD, st(T_S1), st(T_S1), T_S1);
    unique case (pc)
      // deviation from the equilibrium
      7'd0:  r = mk(OP_SUB, st(T_X0), sc(C_XE),     T_XI0);
      7'd1:  r = mk(OP_SUB, st(T_X1), sc(C_XE + 1), T_XI1);
      // an = A' n
      7'd2:  r = mk(OP_MUL, ss(C_A + 0), sn(C_P + 0), T_S1);
      7'd3:  r = mk(OP_MAC, ss(C_A + 2), sn(C_P + 2), T_AN + 0);
      7'd4:  r = mk(OP_MUL, ss(C_A + 0), sn(C_P + 1), T_S1);
      7'd5:  r = mk(OP_MAC, ss(C_A + 2), sn(C_P + 3), T_AN + 1);
      7'd6:  r = mk(OP_MUL, ss(C_A + 1), sn(C_P + 0), T_S1);
      7'd7:  r = mk(OP_MAC, ss(C_A + 3), sn(C_P + 2), T_AN + 2);
      7'd8:  r = mk(OP_MUL, ss(C_A + 1), sn(C_P + 1), T_S1);
      7'd9:  r = mk(OP_MAC, ss(C_A + 3), sn(C_P + 3), T_AN + 3);
      // upper-left block: an A - c
      7'd10: r = mk(OP_MUL, st(T_AN + 0), ss(C_A + 0), T_S1);
      7'd11: r = mk(OP_MAC, st(T_AN + 1), ss(C_A + 2), T_S1);
      7'd12: r = mk(OP_SUB, st(T_S1), sc(C_P + 0), T_F + 0);
      7'd13: r = mk(OP_MUL, st(T_AN + 0), ss(C_A + 1), T_S1);
      7'd14: r = mk(OP_MAC, st(T_AN + 1), ss(C_A + 3), T_S1);
      7'd15: r = mk(OP_SUB, st(T_S1), sc(C_P + 1), T_F + 1);
      7'd16: r = mk(OP_MUL, st(T_AN + 2), ss(C_A + 0), T_S1);
      7'd17: r = mk(OP_MAC, st(T_AN + 3), ss(C_A + 2), T_S1);
      7'd18: r = mk(OP_SUB, st(T_S1), sc(C_P + 2), T_F + 3);
      7'd19: r = mk(OP_MUL, st(T_AN + 2), ss(C_A + 1), T_S1);
      7'd20: r = mk(OP_MAC, st(T_AN + 3), ss(C_A + 3), T_S1);
      7'd21: r = mk(OP_SUB, st(T_S1), sc(C_P + 3), T_F + 4);
      // right column: an ell
      7'd22: r = mk(OP_MUL, st(T_AN + 0), sc(C_ELL),     T_S1);
      7'd23: r = mk(OP_MAC, st(T_AN + 1), sc(C_ELL + 1), T_F + 2);
      7'd24: r = mk(OP_MUL, st(T_AN + 2), sc(C_ELL),     T_S1);
      7'd25: r = mk(OP_MAC, st(T_AN + 3), sc(C_ELL + 1), T_F + 5);
      // ln = ell' n
      7'd26: r = mk(OP_MUL, sc(C_ELL),     sn(C_P + 0), T_S1);
      7'd27: r = mk(OP_MAC, sc(C_ELL + 1), sn(C_P + 2), T_LN + 0);
      7'd28: r = mk(OP_MUL, sc(C_ELL),     sn(C_P + 1), T_S1);
      7'd29: r = mk(OP_MAC, sc(C_ELL + 1), sn(C_P + 3), T_LN + 1);
      // bottom row: ln A, ln ell
      7'd30: r = mk(OP_MUL, st(T_LN + 0), ss(C_A + 0), T_S1);
      7'd31: r = mk(OP_MAC, st(T_LN + 1), ss(C_A + 2), T_F + 6);
      7'd32: r = mk(OP_MUL, st(T_LN + 0), ss(C_A + 1), T_S1);
      7'd33: r = mk(OP_MAC, st(T_LN + 1), ss(C_A + 3), T_F + 7);
      7'd34: r = mk(OP_MUL, st(T_LN + 0), sc(C_ELL),     T_S1);
      7'd35: r = mk(OP_MAC, st(T_LN + 1), sc(C_ELL + 1), T_F + 8);
      // v = [an H + E G ; ln H]
      7'd36: r = mk(OP_MUL, st(T_AN + 0), ss(C_H),     T_S1);
      7'd37: r = mk(OP_MAC, st(T_AN + 1), ss(C_H + 1), T_S1);
      7'd38: r = mk(OP_MUL, ss(C_E + 0), ss(C_G),      T_S2);
      7'd39: r = mk(OP_MAC, ss(C_E + 1), ss(C_G + 1),  T_S2);
      7'd40: r = mk(OP_ADD, st(T_S1), st(T_S2), T_V + 0);
      7'd41: r = mk(OP_MUL, st(T_AN + 2), ss(C_H),     T_S1);
      7'd42: r = mk(OP_MAC, st(T_AN + 3), ss(C_H + 1), T_S1);
      7'd43: r = mk(OP_MUL, ss(C_E + 2), ss(C_G),      T_S2);
      7'd44: r = mk(OP_MAC, ss(C_E + 3), ss(C_G + 1),  T_S2);
      7'd45: r = mk(OP_ADD, st(T_S1), st(T_S2), T_V + 1);
      7'd46: r = mk(OP_MUL, st(T_LN + 0), ss(C_H),     T_S1);
      7'd47: r = mk(OP_MAC, st(T_LN + 1), ss(C_H + 1), T_V + 2);
      // den = H' n H + G' G - rho
      7'd48: r = mk(OP_MUL, ss(C_H),     sn(C_P + 0), T_S1);
      7'd49: r = mk(OP_MAC, ss(C_H + 1), sn(C_P + 2), T_S1);
      7'd50: r = mk(OP_MUL, ss(C_H),     sn(C_P + 1), T_S2);
      7'd51: r = mk(OP_MAC, ss(C_H + 1), sn(C_P + 3), T_S2);
      7'd52: r = mk(OP_MUL, st(T_S1), ss(C_H),     T_S1);
      7'd53: r = mk(OP_MAC, st(T_S2), ss(C_H + 1), T_S1);
      7'd54: r = mk(OP_MUL, ss(C_G),     ss(C_G),     T_S2);
      7'd55: r = mk(OP_MAC, ss(C_G + 1), ss(C_G + 1), T_S2);
      7'd56: r = mk(OP_ADD, st(T_S1), st(T_S2), T_S1);
      7'd57: r = mk(OP_SUB, st(T_S1), st(T_RHO), T_DEN);
      // F = L - v v' / den
      7'd58: r = mk(OP_MDV, st(T_V + 0), st(T_V + 0), T_S1);
      7'd59: r = mk(OP_SUB, st(T_F + 0), st(T_S1), T_F + 0);
      7'd60: r = mk(OP_MDV, st(T_V + 0), st(T_V + 1), T_S1);
      7'd61: r = mk(OP_SUB, st(T_F + 1), st(T_S1), T_F + 1);
      7'd62: r = mk(OP_MDV, st(T_V + 0), st(T_V + 2), T_S1);
      7'd63: r = mk(OP_SUB, st(T_F + 2), st(T_S1), T_F + 2);
      7'd64: r = mk(OP_MDV, st(T_V + 1), st(T_V + 0), T_S1);
      7'd65: r = mk(OP_SUB, st(T_F + 3), st(T_S1), T_F + 3);
      7'd66: r = mk(OP_MDV, st(T_V + 1), st(T_V + 1), T_S1);
      7'd67: r = mk(OP_SUB, st(T_F + 4), st(T_S1), T_F + 4);
      7'd68: r = mk(OP_MDV, st(T_V + 1), st(T_V + 2), T_S1);
      7'd69: r = mk(OP_SUB, st(T_F + 5), st(T_S1), T_F + 5);
      7'd70: r = mk(OP_MDV, st(T_V + 2), st(T_V + 0), T_S1);
      7'd71: r = mk(OP_SUB, st(T_F + 6), st(T_S1), T_F + 6);
      7'd72: r = mk(OP_MDV, st(T_V + 2), st(T_V + 1), T_S1);
      7'd73: r = mk(OP_SUB, st(T_F + 7), st(T_S1), T_F + 7);
      7'd74: r = mk(OP_MDV, st(T_V + 2), st(T_V + 2), T_S1);
      7'd75: r = mk(OP_SUB, st(T_F + 8), st(T_S1), T_F + 8);
      // f1 = [xi;1]' F
      7'd76: r = mk(OP_MUL, st(T_XI0), st(T_F + 0), T_S1);
      7'd77: r = mk(OP_MAC, st(T_XI1), st(T_F + 3), T_S1);
      7'd78: r = mk(OP_ADD, st(T_S1), st(T_F + 6), T_F1 + 0);
      7'd79: r = mk(OP_MUL, st(T_XI0), st(T_F + 1), T_S1);
      7'd80: r = mk(OP_MAC, st(T_XI1), st(T_F + 4), T_S1);
      7'd81: r = mk(OP_ADD, st(T_S1), st(T_F + 7), T_F1 + 1);
      7'd82: r = mk(OP_MUL, st(T_XI0), st(T_F + 2), T_S1);
      7'd83: r = mk(OP_MAC, st(T_XI1), st(T_F + 5), T_S1);
      7'd84: r = mk(OP_ADD, st(T_S1), st(T_F + 8), T_F1 + 2);
      // f2 = xi' Q
      7'd85: r = mk(OP_MUL, st(T_XI0), ss(C_Q + 0), T_S1);
      7'd86: r = mk(OP_MAC, st(T_XI1), ss(C_Q + 2), T_F2 + 0);
      7'd87: r = mk(OP_MUL, st(T_XI0), ss(C_Q + 1), T_S1);
      7'd88: r = mk(OP_MAC, st(T_XI1), ss(C_Q + 3), T_F2 + 1);
      // cost = f1 [xi;1] - f2 xi
      7'd89: r = mk(OP_MUL, st(T_F1 + 0), st(T_XI0), T_S1);
      7'd90: r = mk(OP_MAC, st(T_F1 + 1), st(T_XI1), T_S1);
      7'd91: r = mk(OP_ADD, st(T_S1), st(T_F1 + 2), T_S1);
      7'd92: r = mk(OP_MUL, st(T_F2 + 0), st(T_XI0), T_S2);
      7'd93: r = mk(OP_MAC, st(T_F2 + 1), st(T_XI1), T_S2);
      7'd94: r = mk(OP_SUB, st(T_S1), st(T_S2), T_S1);
      default: r = mk(OP_ADD, st(T_S1), st(T_S1), T_S1);
    endcase
    return r;
  endfunction

  // Signed value from sign and magnitude, saturated to 48 bits
  function automatic logic signed [QW-1:0] from_mag(input logic neg, input logic [49:0] m,
                                                    input logic over);
    logic signed [QW-1:0] r;
    if (neg) begin
      if (over || m > 50'h0800000000000) r = QMIN;
      else r = QW'(-m);
    end else begin
      if (over || m > 50'h07FFFFFFFFFFF) r = QMAX;
      else r = QW'(m);
    end
    return r;
  endfunction

  function automatic logic signed [QW-1:0] sadd(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic [QW:0] s;
    logic signed [QW-1:0] r;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] != s[QW-1]) r = s[QW] ? QMIN : QMAX;
    else r = s[QW-1:0];
    return r;
  endfunction

  function automatic logic signed [QW-1:0] ssub(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic [QW:0] s;
    logic signed [QW-1:0] r;
    s = {a[QW-1], a} - {b[QW-1], b};
    if (s[QW] != s[QW-1]) r = s[QW] ? QMIN : QMAX;
    else r = s[QW-1:0];
    return r;
  endfunction

endpackage

[hdl/limit_cycle_switching_rule_core.sv]
// Switching rule for a second-order switched converter on a limit cycle.
// Depends on lcsr_pkg and lcsr_ram (coefficient store and scratch words).
`timescale 1ns / 1ps
//
//  channel  direction  handshake               word
//  in       input      in_valid / in_stall     func, coef_index, coef_value, state_x0/x1
//  out      output     out_valid / out_stall   chosen_subsystem, best_cost, cycle_step
//  cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A coefficient write is done as soon as it is accepted. A state sample passes the load
// states, then the next step index is reduced modulo the cycle length by repeated
// subtraction (at most one while the step stays inside the cycle, up to 64 after
// the cycle is shortened), then each evaluated subsystem runs its program
// (95 micro-operations on one shared 24x24 multiplier and a bit-serial divider),
// then the word is posted.
// Reset (rst, synchronous) clears the sequencer, the step index, out_valid and the
// configuration registers; the coefficient store has no reset. The block takes no input
// while a sample is at work; a finished word waits in the output register
// and holds the next sample only at its very end.

module limit_cycle_switching_rule_core
  import lcsr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input words
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   func,
  input  logic [10:0]            coef_index,
  input  logic signed [QW-1:0]   coef_value,
  input  logic signed [QW-1:0]   state_x0,
  input  logic signed [QW-1:0]   state_x1,
  // result words
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             chosen_subsystem,
  output logic signed [QW-1:0]   best_cost,
  output logic [STEP_W-1:0]      cycle_step,
  // configuration
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [QW-1:0]          cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LD   = 4'd1;
  localparam logic [3:0] S_FA   = 4'd2;
  localparam logic [3:0] S_FB   = 4'd3;
  localparam logic [3:0] S_WB   = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_ALU  = 4'd7;
  localparam logic [3:0] S_CMP  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;
  localparam logic [3:0] S_MOD  = 4'd10;

  logic [3:0]             state;
  logic [PC_W-1:0]        pc;
  logic [SUB_W-1:0]       sub;
  logic [6:0]             cnt;
  logic [STEP_W-1:0]      step_index;
  logic [LEN_W-1:0]       nxt_step;
  logic [LEN_W-1:0]       cycle_length;
  logic [CNT_W-1:0]       subsystem_count;
  logic signed [QW-1:0]   rho;
  logic signed [QW-1:0]   sx0, sx1;
  logic signed [QW-1:0]   opa, opb, res, den, best;
  logic [1:0]             best_id;
  logic [PROD_W-1:0]      prod;
  logic [QW-1:0]          rem;
  logic [QW:0]            quo;
  logic                   dover;

  logic                   in_acc;
  instr_t                 instr;
  logic [LEN_W-1:0]       len_eff;
  logic [CNT_W-1:0]       cnt_eff;
  logic [STEP_W-1:0]      kn;
  logic [6:0]             src;
  logic [3:0]             cur_off;
  logic [ADDR_W-1:0]      coef_raddr;
  logic [QW-1:0]          coef_rdata;
  logic                   coef_we;
  logic [QW-1:0]          tmp_rdata;
  logic                   tmp_we;
  logic [TMP_W-1:0]       tmp_waddr;
  logic [QW-1:0]          tmp_wdata;
  logic [QW-1:0]          rd_a, rd_b;
  logic [QW-1:0]          ma, mb, ds;
  logic [23:0]            ah, bh;
  logic [47:0]            pp;
  logic [PROD_W-1:0]      pp_sh;
  logic [QW:0]            r2, rn;
  logic [QW+1:0]          q2;
  logic                   ge;
  logic                   q_over;
  logic [QW:0]            mm;
  logic signed [QW-1:0]   qfin, dfin, alu_res, cost;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign instr     = lcsr_prog(pc);

  // clamp the configuration to its working range
  always_comb begin
    if (cycle_length == '0) len_eff = LEN_W'(1);
    else if (cycle_length > LEN_W'(MAX_STEPS)) len_eff = LEN_W'(MAX_STEPS);
    else len_eff = cycle_length;
    if (subsystem_count == '0) cnt_eff = CNT_W'(1);
    else if (subsystem_count > CNT_W'(NUM_SUB)) cnt_eff = CNT_W'(NUM_SUB);
    else cnt_eff = subsystem_count;
  end

  // step index for the next sample: wrap to zero at the end of the cycle
  assign kn = (({1'b0, step_index} + LEN_W'(1)) >= len_eff) ? '0 : step_index + 1'b1;

  // operand address: a in the first fetch cycle, b in the second
  assign src     = (state == S_FA) ? instr.a : instr.b;
  assign cur_off = src[3:0] + ((src[4:0] >= TMP_W'(C_ELL)) ? {1'b0, sub, 1'b0} : 4'd0);

  always_comb begin
    unique case (src[6:5])
      K_SUB:   coef_raddr = ADDR_W'({sub, src[3:0]});
      K_CUR:   coef_raddr = ADDR_W'(STEP_BASE) + ADDR_W'({step_index, 4'd0})
                            + ADDR_W'(cur_off);
      K_NXT:   coef_raddr = ADDR_W'(STEP_BASE) + ADDR_W'({nxt_step[STEP_W-1:0], 4'd0})
                            + ADDR_W'(src[3:0]);
      default: coef_raddr = '0;
    endcase
  end

  assign coef_we = in_acc && !func && (coef_index < ADDR_W'(MEM_DEPTH));

  lcsr_ram #(.WIDTH(QW), .DEPTH(MEM_DEPTH)) u_coef (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_index),
    .wdata (coef_value),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  // scratch writes: sample and rho at load, results after each operation
  always_comb begin
    tmp_we    = 1'b0;
    tmp_waddr = instr.dst;
    tmp_wdata = alu_res;
    if (state == S_LD) begin
      tmp_we = 1'b1;
      unique case (cnt[1:0])
        2'd0:    begin tmp_waddr = TMP_W'(T_X0); tmp_wdata = sx0; end
        2'd1:    begin tmp_waddr = TMP_W'(T_X1); tmp_wdata = sx1; end
        default: begin tmp_waddr = TMP_W'(T_RHO); tmp_wdata = rho; end
      endcase
    end else if (state == S_ALU) begin
      tmp_we = 1'b1;
    end
  end

  lcsr_ram #(.WIDTH(QW), .DEPTH(TMP_DEPTH)) u_tmp (
    .clk   (clk),
    .we    (tmp_we),
    .waddr (tmp_waddr),
    .wdata (tmp_wdata),
    .raddr (src[TMP_W-1:0]),
    .rdata (tmp_rdata)
  );

  assign rd_a = (instr.a[6:5] == K_TMP) ? tmp_rdata : coef_rdata;
  assign rd_b = (instr.b[6:5] == K_TMP) ? tmp_rdata : coef_rdata;

  // shared multiplier: one 24x24 partial product per cycle
  assign ma = opa[QW-1] ? QW'(-opa) : opa;
  assign mb = opb[QW-1] ? QW'(-opb) : opb;
  assign ds = den[QW-1] ? QW'(-den) : den;
  assign ah = cnt[1] ? ma[47:24] : ma[23:0];
  assign bh = cnt[0] ? mb[47:24] : mb[23:0];
  assign pp = ah * bh;

  always_comb begin
    unique case (cnt[1:0])
      2'd0:    pp_sh = {48'd0, pp};
      2'd3:    pp_sh = {pp, 48'd0};
      default: pp_sh = {24'd0, pp, 24'd0};
    endcase
  end

  // divider step: one quotient bit per cycle from the product's top bit
  always_comb begin
    r2 = {rem, prod[PROD_W-1]};
    ge = (r2 >= {1'b0, ds});
    rn = ge ? (r2 - {1'b0, ds}) : r2;
    q2 = {quo, ge};
    q_over = (q2 > 50'h1000000000000);
  end

  // round the product toward minus infinity and saturate
  assign mm   = {1'b0, prod[71:24]} + (QW+1)'(opa[QW-1] ^ opb[QW-1] && (|prod[23:0])
                                              && !(|prod[95:72]));
  assign qfin = from_mag(opa[QW-1] ^ opb[QW-1], {1'b0, mm}, |prod[95:72]);
  assign dfin = from_mag(opa[QW-1] ^ opb[QW-1] ^ den[QW-1], {1'b0, quo}, dover);

  always_comb begin
    unique case (instr.op)
      OP_MUL:  alu_res = qfin;
      OP_MAC:  alu_res = sadd(res, qfin);
      OP_ADD:  alu_res = sadd(opa, opb);
      OP_SUB:  alu_res = ssub(opa, opb);
      OP_MDV:  alu_res = dfin;
      default: alu_res = opa;
    endcase
  end

  // a zero denominator saturates the cost
  assign cost = (den == '0) ? QMAX : res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_length    <= LEN_W'(1);
      subsystem_count <= CNT_W'(1);
      rho             <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CYCLE_LENGTH:    cycle_length    <= cfg_data[LEN_W-1:0];
        CFG_SUBSYSTEM_COUNT: subsystem_count <= cfg_data[CNT_W-1:0];
        CFG_RHO:             rho             <= cfg_data;
        default:             ;
      endcase
    end
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pc         <= '0;
      sub        <= '0;
      cnt        <= '0;
      step_index <= '0;
      out_valid  <= 1'b0;
    end else begin
      // drop a taken word unless the posting state replaces it
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && func) begin
            sx0      <= state_x0;
            sx1      <= state_x1;
            nxt_step <= {1'b0, step_index} + LEN_W'(1);
            cnt      <= '0;
            state    <= S_LD;
          end
        end
        S_LD: begin
          cnt <= cnt + 1'b1;
          if (cnt[1:0] == 2'd2) begin
            pc    <= '0;
            sub   <= '0;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          // reduce the next step index modulo the cycle length
          if (nxt_step >= len_eff) nxt_step <= nxt_step - len_eff;
          else state <= S_FA;
        end
        S_FA: begin
          state <= S_FB;
        end
        S_FB: begin
          opa   <= rd_a;
          state <= S_WB;
        end
        S_WB: begin
          opb   <= rd_b;
          prod  <= '0;
          rem   <= '0;
          quo   <= '0;
          dover <= 1'b0;
          cnt   <= '0;
          if (instr.op == OP_ADD || instr.op == OP_SUB) state <= S_ALU;
          else state <= S_MUL;
        end
        S_MUL: begin
          prod <= prod + pp_sh;
          cnt  <= cnt + 1'b1;
          if (cnt[1:0] == 2'd3) begin
            cnt   <= '0;
            state <= (instr.op == OP_MDV) ? S_DIV : S_ALU;
          end
        end
        S_DIV: begin
          prod <= {prod[PROD_W-2:0], 1'b0};
          rem  <= rn[QW-1:0];
          if (q_over) begin
            dover <= 1'b1;
            quo   <= {1'b1, {QW{1'b0}}};
          end else begin
            quo <= q2[QW:0];
          end
          cnt <= cnt + 1'b1;
          if (cnt == 7'(DIV_STEPS - 1)) state <= S_ALU;
        end
        S_ALU: begin
          res <= alu_res;
          if (instr.dst == TMP_W'(T_DEN)) den <= alu_res;
          if (pc == PC_W'(PROG_LEN - 1)) begin
            state <= S_CMP;
          end else begin
            pc    <= pc + 1'b1;
            state <= S_FA;
          end
        end
        S_CMP: begin
          if (sub == '0 || cost < best) begin
            best    <= cost;
            best_id <= sub;
          end
          if (CNT_W'(sub) + CNT_W'(1) < cnt_eff) begin
            sub   <= sub + 1'b1;
            pc    <= '0;
            state <= S_FA;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // post the word once the output register is free
          if (!out_valid || !out_stall) begin
            out_valid        <= 1'b1;
            chosen_subsystem <= best_id;
            best_cost        <= best;
            cycle_step       <= step_index;
            step_index       <= kn;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a new word appears only from the posting state
  a_post_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result word posted outside the posting state");

  // the program counter stays inside the program
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    state == S_FA |-> pc < PC_W'(PROG_LEN))
    else $error("program counter beyond the program");

  // only configured subsystems are evaluated
  a_sub_range: assert property (@(posedge clk) disable iff (rst)
    state == S_FA |-> CNT_W'(sub) < cnt_eff)
    else $error("subsystem index beyond the configured count");

  // the divider never runs longer than its bit count
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt < 7'(DIV_STEPS))
    else $error("divider overran its steps");

endmodule

[hdl/lcsr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lcsr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
